// File: rtl/noisy_or_nor_node_likelihood_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the noisy-OR/NOR node likelihood block.
// ----------------------------------------------------------------------------
`ifndef NOISY_OR_NOR_NODE_LIKELIHOOD_MACROS_SVH
`define NOISY_OR_NOR_NODE_LIKELIHOOD_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NONL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define NONL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/nonl_pkg.sv
// ----------------------------------------------------------------------------
// nonl_pkg
// Shared constants and types of the noisy-OR/NOR node likelihood block.
// ----------------------------------------------------------------------------
package nonl_pkg;

    // Default number of fraction bits of all probability values.
    localparam int FRACTION_BITS_DEFAULT = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_STATE = 2'd0,
        CFG_BG_ZERO    = 2'd1,
        CFG_BG_ONE     = 2'd2,
        CFG_BG_TWO     = 2'd3
    } t_cfg_reg;

    // Parent sign codes; the unused code is ignored like a neutral parent.
    localparam logic [1:0] SIGN_INHIBIT  = 2'd0;
    localparam logic [1:0] SIGN_NEUTRAL  = 2'd1;
    localparam logic [1:0] SIGN_ACTIVATE = 2'd2;
    localparam logic [1:0] SIGN_UNUSED   = 2'd3;

    // Node state codes; the invalid state yields a likelihood of zero.
    localparam logic [1:0] NODE_ZERO    = 2'd0;
    localparam logic [1:0] NODE_ONE     = 2'd1;
    localparam logic [1:0] NODE_TWO     = 2'd2;
    localparam logic [1:0] NODE_INVALID = 2'd3;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CMP  = 9'b000000010,
        S_FAC  = 9'b000000100,
        S_ACC  = 9'b000001000,
        S_UPD  = 9'b000010000,
        S_PRD  = 9'b000100000,
        S_LEAD = 9'b001000000,
        S_LEAK = 9'b010000000,
        S_SUM  = 9'b100000000
    } t_state;

endpackage

// File: rtl/nonl_fxmul.sv
// ----------------------------------------------------------------------------
// nonl_fxmul
// Shared fixed-point multiplier with a registered, truncated product.
// ----------------------------------------------------------------------------
module nonl_fxmul #(
    parameter int FRACTION_BITS = nonl_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                     i_clk,
    input  logic [FRACTION_BITS:0]   i_a,
    input  logic [FRACTION_BITS:0]   i_b,
    output logic [FRACTION_BITS:0]   o_prod
);

    localparam int W = FRACTION_BITS + 1;

    logic [2*W-1:0] full_prod;
    logic [W-1:0]   r_prod;

    // Both operands are at most one, so the truncated product fits in W bits.
    assign full_prod = {{W{1'b0}}, i_a} * {{W{1'b0}}, i_b};

    always_ff @(posedge i_clk) begin
        r_prod <= full_prod[FRACTION_BITS +: W];
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/nonl_cfg.sv
// ----------------------------------------------------------------------------
// nonl_cfg
// Configuration registers: node state and the three background probabilities,
// saturated to one as they are written.
// ----------------------------------------------------------------------------
module nonl_cfg #(
    parameter int FRACTION_BITS = nonl_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [nonl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [FRACTION_BITS:0]            i_cfg_data,
    output logic [1:0]                        o_node_state,
    output logic [FRACTION_BITS:0]            o_bg_zero,
    output logic [FRACTION_BITS:0]            o_bg_one,
    output logic [FRACTION_BITS:0]            o_bg_two
);

    localparam int W = FRACTION_BITS + 1;
    localparam logic [W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    logic [W-1:0] data_sat;
    logic [1:0]   r_node_state;
    logic [W-1:0] r_bg_zero;
    logic [W-1:0] r_bg_one;
    logic [W-1:0] r_bg_two;

    // Probabilities above one are held as one.
    assign data_sat = (i_cfg_data > ONE) ? ONE : i_cfg_data;

    // Register write decode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_state <= '0;
            r_bg_zero    <= '0;
            r_bg_one     <= '0;
            r_bg_two     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (nonl_pkg::t_cfg_reg'(i_cfg_index))
                nonl_pkg::CFG_NODE_STATE: r_node_state <= i_cfg_data[1:0];
                nonl_pkg::CFG_BG_ZERO:    r_bg_zero    <= data_sat;
                nonl_pkg::CFG_BG_ONE:     r_bg_one     <= data_sat;
                nonl_pkg::CFG_BG_TWO:     r_bg_two     <= data_sat;
                default: ;
            endcase
        end
    end

    assign o_node_state = r_node_state;
    assign o_bg_zero    = r_bg_zero;
    assign o_bg_one     = r_bg_one;
    assign o_bg_two     = r_bg_two;

endmodule

// File: rtl/noisy_or_nor_node_likelihood.sv
// ----------------------------------------------------------------------------
// noisy_or_nor_node_likelihood
// Noisy-OR/NOR likelihood of a three-state node, built around one shared
// fixed-point multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// One parent is taken per input transfer. A parent with sign inhibit or
// activate occupies the block for the transfer cycle, three multiplies
// through the single shared multiplier and the accumulator write-back; a
// neutral parent, or one with sign three, needs only its transfer cycle. A
// parent marked last then adds the steps PRD, LEAD, LEAK and SUM, which
// combine the products with the node state and the background probability;
// SUM waits while the previous result still sits unaccepted in the output
// register. Input stall is high whenever the sequencer is not idle. Values
// are unsigned fixed point with FRACTION_BITS fraction bits; inputs above one
// are treated as one and every product is truncated.
// ----------------------------------------------------------------------------
`include "noisy_or_nor_node_likelihood_macros.svh"

module noisy_or_nor_node_likelihood #(
    parameter int FRACTION_BITS = nonl_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_wr_en,
    input  logic [nonl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [FRACTION_BITS:0]            i_cfg_data,
    // Parent input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [FRACTION_BITS:0]            i_parent_weight,
    input  logic [FRACTION_BITS:0]            i_parent_strength,
    input  logic                              i_parent_active,
    input  logic [1:0]                        i_parent_sign,
    input  logic                              i_last_parent,
    // Likelihood output channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [FRACTION_BITS:0]            o_likelihood
);

    localparam int W = FRACTION_BITS + 1;
    localparam logic [W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    nonl_pkg::t_state r_state, n_state;

    logic [1:0]   node_state;
    logic [W-1:0] bg_zero, bg_one, bg_two;

    logic [W-1:0] r_z, r_t;
    logic         r_active, r_last;
    logic [1:0]   r_sign;
    logic [W-1:0] r_comp, r_p0, r_p2, r_lead;
    logic         r_out_valid;
    logic [W-1:0] r_like;

    logic [W-1:0] mul_a, mul_b, prod;
    logic [W-1:0] lead_opnd, bg_sel;
    logic [W:0]   sum;
    logic [W-1:0] result;
    logic         in_xfer, out_free, sum_go, sign_used;

    // Configuration registers.
    nonl_cfg #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_node_state (node_state),
        .o_bg_zero    (bg_zero),
        .o_bg_one     (bg_one),
        .o_bg_two     (bg_two)
    );

    // The shared multiplier; its product is registered and ready in the cycle after issue.
    nonl_fxmul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Handshake terms.
    assign o_in_stall = (r_state != nonl_pkg::S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign sum_go     = (r_state == nonl_pkg::S_SUM) && out_free;
    assign sign_used  = (i_parent_sign == nonl_pkg::SIGN_INHIBIT) ||
                        (i_parent_sign == nonl_pkg::SIGN_ACTIVATE);

    // Operand of the lead term, by node state.
    always_comb begin
        case (node_state)
            nonl_pkg::NODE_ZERO: lead_opnd = ONE - r_p0;
            nonl_pkg::NODE_ONE:  lead_opnd = prod;
            default:             lead_opnd = r_p0 - prod;
        endcase
    end

    // Background probability, by node state.
    always_comb begin
        case (node_state)
            nonl_pkg::NODE_ZERO: bg_sel = bg_zero;
            nonl_pkg::NODE_ONE:  bg_sel = bg_one;
            default:             bg_sel = bg_two;
        endcase
    end

    // Multiplier operand selection per sequencer step.
    always_comb begin
        mul_a = r_comp;
        mul_b = ONE - r_z;
        unique case (r_state)
            nonl_pkg::S_CMP: begin
                mul_a = r_comp;
                mul_b = ONE - r_z;
            end
            nonl_pkg::S_FAC: begin
                mul_a = r_active ? (ONE - r_t) : ONE;
                mul_b = r_z;
            end
            nonl_pkg::S_ACC: begin
                mul_a = (r_sign == nonl_pkg::SIGN_INHIBIT) ? r_p0 : r_p2;
                mul_b = prod;
            end
            nonl_pkg::S_PRD: begin
                mul_a = r_p0;
                mul_b = r_p2;
            end
            nonl_pkg::S_LEAD: begin
                mul_a = lead_opnd;
                mul_b = ONE - r_comp;
            end
            nonl_pkg::S_LEAK: begin
                mul_a = r_comp;
                mul_b = bg_sel;
            end
            // Keep issuing the leak term so it stays put while the output waits.
            nonl_pkg::S_SUM: begin
                mul_a = r_comp;
                mul_b = bg_sel;
            end
            default: ;
        endcase
    end

    // Final sum, saturated to one; an undefined node state gives zero.
    assign sum = {1'b0, r_lead} + {1'b0, prod};
    always_comb begin
        if (node_state == nonl_pkg::NODE_INVALID) begin
            result = '0;
        end else if (sum > {1'b0, ONE}) begin
            result = ONE;
        end else begin
            result = sum[W-1:0];
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nonl_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if (sign_used) begin
                        n_state = nonl_pkg::S_CMP;
                    end else if (i_last_parent) begin
                        n_state = nonl_pkg::S_PRD;
                    end
                end
            end
            nonl_pkg::S_CMP:  n_state = nonl_pkg::S_FAC;
            nonl_pkg::S_FAC:  n_state = nonl_pkg::S_ACC;
            nonl_pkg::S_ACC:  n_state = nonl_pkg::S_UPD;
            nonl_pkg::S_UPD:  n_state = r_last ? nonl_pkg::S_PRD : nonl_pkg::S_IDLE;
            nonl_pkg::S_PRD:  n_state = nonl_pkg::S_LEAD;
            nonl_pkg::S_LEAD: n_state = nonl_pkg::S_LEAK;
            nonl_pkg::S_LEAK: n_state = nonl_pkg::S_SUM;
            nonl_pkg::S_SUM: begin
                if (out_free) begin
                    n_state = nonl_pkg::S_IDLE;
                end
            end
            default: n_state = nonl_pkg::S_IDLE;
        endcase
    end

    // Control state: sequencer, accumulators and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nonl_pkg::S_IDLE;
            r_comp      <= ONE;
            r_p0        <= ONE;
            r_p2        <= ONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == nonl_pkg::S_FAC) begin
                r_comp <= prod;
            end
            if (r_state == nonl_pkg::S_UPD) begin
                if (r_sign == nonl_pkg::SIGN_INHIBIT) begin
                    r_p0 <= prod;
                end else begin
                    r_p2 <= prod;
                end
            end
            if (sum_go) begin
                r_comp <= ONE;
                r_p0   <= ONE;
                r_p2   <= ONE;
            end
            if (sum_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: the accepted parent, the lead term and the result.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_z      <= (i_parent_weight > ONE) ? ONE : i_parent_weight;
            r_t      <= (i_parent_strength > ONE) ? ONE : i_parent_strength;
            r_active <= i_parent_active;
            r_sign   <= i_parent_sign;
            r_last   <= i_last_parent;
        end
        if (r_state == nonl_pkg::S_LEAK) begin
            r_lead <= prod;
        end
        if (sum_go) begin
            r_like <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_likelihood = r_like;

    // A result appears only out of the final summing step.
    `NONL_ASSERT_NEXT(a_out_from_sum, i_clk, i_rst_n, !r_out_valid && !sum_go, !r_out_valid, "output valid rose outside the summing step")
    // The accumulators return to one once a likelihood is registered for output.
    `NONL_ASSERT_NEXT(a_clear_after_sum, i_clk, i_rst_n, sum_go, (r_comp == ONE) && (r_p0 == ONE) && (r_p2 == ONE), "accumulators not cleared after a result")
    // Running products never exceed one.
    `NONL_ASSERT_NOW(a_prod_range, i_clk, i_rst_n, 1'b1, (r_comp <= ONE) && (r_p0 <= ONE) && (r_p2 <= ONE), "running product above one")
    // A last parent always proceeds into the final combination.
    `NONL_ASSERT_NEXT(a_last_to_final, i_clk, i_rst_n, (r_state == nonl_pkg::S_UPD) && r_last, r_state == nonl_pkg::S_PRD, "last parent did not start the final combination")

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the noisy-OR/NOR node likelihood block
// Walks a short table of directed parents and register writes, then runs
// random evaluations over many register settings. Every likelihood is checked
// in order against an independent fixed-point model of the node, with random
// idle cycles on the parent channel and random stall on the likelihood channel.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    FB           = nonl_pkg::FRACTION_BITS_DEFAULT;
    localparam int    W            = FB + 1;
    localparam real   CLK_PERIOD   = 12.0;
    localparam int    RANDOM_ITEMS = 1100;
    localparam int    PHASE_ITEMS  = 80;
    localparam int    SETTLE       = 12;
    localparam int    LONG_HOLD    = 300;
    localparam int    QUIET_LIMIT  = 2000;
    localparam int    DRAIN        = 20;

    typedef logic [W-1:0] t_prob;

    localparam t_prob UNITY    = {1'b1, {FB{1'b0}}};
    localparam t_prob MAX_CODE = '1;

    typedef struct packed {
        t_prob      weight;
        t_prob      strength;
        logic       active;
        logic [1:0] sign;
        logic       last;
    } t_parent;

    typedef struct packed {
        logic               is_write;
        nonl_pkg::t_cfg_reg sel;
        t_prob              value;
        t_parent            par;
        logic               typed;
        t_prob              typed_lik;
    } t_stim_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    logic [nonl_pkg::CFG_IDX_W-1:0] i_cfg_index;
    t_prob                          i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_stall;
    t_prob                          i_parent_weight;
    t_prob                          i_parent_strength;
    logic                           i_parent_active;
    logic [1:0]                     i_parent_sign;
    logic                           i_last_parent;
    logic                           o_out_valid;
    logic                           i_out_stall;
    t_prob                          o_likelihood;

    // Model copy of the registers and the three running products.
    logic [1:0] node_sel;
    t_prob      leak_zero, leak_one, leak_two;
    t_prob      complement_acc, inhibit_acc, activate_acc;

    t_prob      pending_likelihoods[$];
    t_stim_row  directed_rows[$];
    t_prob      want_lik;
    int         errors;
    int         results_seen;
    bit         no_idle;
    bit         held_long;

    noisy_or_nor_node_likelihood #(
        .FRACTION_BITS(FB)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_parent_weight  (i_parent_weight),
        .i_parent_strength(i_parent_strength),
        .i_parent_active  (i_parent_active),
        .i_parent_sign    (i_parent_sign),
        .i_last_parent    (i_last_parent),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_likelihood     (o_likelihood)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    // Probabilities above one count as one.
    function automatic t_prob sat_unity(input t_prob v);
        return (v > UNITY) ? UNITY : v;
    endfunction

    // Truncating fixed-point product of two values no larger than one.
    function automatic t_prob fx_mult(input t_prob a, input t_prob b);
        logic [2*W-1:0] full;
        full = a * b;
        return t_prob'(full >> FB);
    endfunction

    function automatic void clear_products();
        complement_acc = UNITY;
        inhibit_acc    = UNITY;
        activate_acc   = UNITY;
    endfunction

    // Folds one parent into the products; on the last parent it yields the
    // node likelihood and clears the products.
    function automatic bit predict_parent(input t_parent p, output t_prob lik);
        t_prob      z, t, factor, c, inv_c, p0, p2, lead, leak;
        logic [W:0] sum;
        z   = sat_unity(p.weight);
        t   = sat_unity(p.strength);
        lik = '0;
        if (p.sign == nonl_pkg::SIGN_INHIBIT || p.sign == nonl_pkg::SIGN_ACTIVATE) begin
            factor         = fx_mult(p.active ? UNITY - t : UNITY, z);
            complement_acc = fx_mult(complement_acc, UNITY - z);
            if (p.sign == nonl_pkg::SIGN_INHIBIT) begin
                inhibit_acc = fx_mult(inhibit_acc, factor);
            end else begin
                activate_acc = fx_mult(activate_acc, factor);
            end
        end
        if (!p.last) begin
            return 1'b0;
        end
        c     = complement_acc;
        inv_c = UNITY - c;
        p0    = inhibit_acc;
        p2    = activate_acc;
        case (node_sel)
            nonl_pkg::NODE_ZERO: begin
                lead = fx_mult(UNITY - p0, inv_c);
                leak = fx_mult(c, sat_unity(leak_zero));
            end
            nonl_pkg::NODE_ONE: begin
                lead = fx_mult(fx_mult(p0, p2), inv_c);
                leak = fx_mult(c, sat_unity(leak_one));
            end
            nonl_pkg::NODE_TWO: begin
                lead = fx_mult(p0 - fx_mult(p2, p0), inv_c);
                leak = fx_mult(c, sat_unity(leak_two));
            end
            default: begin
                lead = '0;
                leak = '0;
            end
        endcase
        sum = {1'b0, lead} + {1'b0, leak};
        lik = (sum > UNITY) ? UNITY : sum[W-1:0];
        clear_products();
        return 1'b1;
    endfunction

    function automatic void add_write(input nonl_pkg::t_cfg_reg sel, input t_prob value);
        t_stim_row row;
        row          = '0;
        row.is_write = 1'b1;
        row.sel      = sel;
        row.value    = value;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_item(input t_prob w, input t_prob t, input logic x,
                                     input logic [1:0] s, input logic last,
                                     input logic typed, input t_prob typed_lik);
        t_stim_row row;
        row           = '0;
        row.par       = '{weight: w, strength: t, active: x, sign: s, last: last};
        row.typed     = typed;
        row.typed_lik = typed_lik;
        directed_rows = {directed_rows, row};
    endfunction

    // Mostly plain probabilities, with the extremes, small values and
    // out-of-range codes mixed in.
    function automatic t_prob random_prob();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return UNITY;
            2:       return t_prob'($urandom_range(int'(UNITY) + 1, int'(MAX_CODE)));
            3:       return t_prob'($urandom_range(0, int'(UNITY) / 16));
            default: return t_prob'($urandom_range(0, int'(UNITY)));
        endcase
    endfunction

    function automatic t_parent random_parent(input bit closing);
        t_parent p;
        int      pick;
        p.weight   = random_prob();
        p.strength = random_prob();
        p.active   = 1'($urandom_range(0, 1));
        pick       = $urandom_range(0, 9);
        if (pick < 4) begin
            p.sign = nonl_pkg::SIGN_INHIBIT;
        end else if (pick < 8) begin
            p.sign = nonl_pkg::SIGN_ACTIVATE;
        end else if (pick == 8) begin
            p.sign = nonl_pkg::SIGN_NEUTRAL;
        end else begin
            p.sign = nonl_pkg::SIGN_UNUSED;
        end
        // An early last bit now and then cuts an evaluation short.
        p.last = closing || ($urandom_range(0, 15) == 0);
        return p;
    endfunction

    // Register writes happen only once the block has drained and settled.
    task automatic write_register(input nonl_pkg::t_cfg_reg sel, input t_prob value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_likelihoods.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= value;
        case (sel)
            nonl_pkg::CFG_NODE_STATE: node_sel  = value[1:0];
            nonl_pkg::CFG_BG_ZERO:    leak_zero = value;
            nonl_pkg::CFG_BG_ONE:     leak_one  = value;
            default:                  leak_two  = value;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // One parent transfer after a random idle gap; the model runs on acceptance.
    task automatic send_parent(input t_parent p, input logic typed, input t_prob typed_lik);
        int    gap;
        t_prob lik;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid        <= 1'b1;
        i_parent_weight   <= p.weight;
        i_parent_strength <= p.strength;
        i_parent_active   <= p.active;
        i_parent_sign     <= p.sign;
        i_last_parent     <= p.last;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_parent(p, lik)) begin
            pending_likelihoods = {pending_likelihoods, (typed ? typed_lik : lik)};
        end
    endtask

    // New register values for one random phase; every few phases the node
    // state is invalid, and some writes carry junk above the state bits.
    task automatic retune_phase(input int phase);
        t_prob data;
        data = (phase % 7 == 6) ? t_prob'(nonl_pkg::NODE_INVALID) : t_prob'(phase % 3);
        if ($urandom_range(0, 3) == 0) begin
            data[W-1:2] = (W - 2)'($urandom);
        end
        write_register(nonl_pkg::CFG_NODE_STATE, data);
        write_register(nonl_pkg::CFG_BG_ZERO, random_prob());
        write_register(nonl_pkg::CFG_BG_ONE, random_prob());
        write_register(nonl_pkg::CFG_BG_TWO, random_prob());
    endtask

    // Likelihood receiver: random stall per transfer, plus one long hold-off
    // that backs the block up into its input.
    initial begin
        int hold;
        i_out_stall = 1'b0;
        held_long   = 1'b0;
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 9);
            if (!held_long && results_seen >= 30) begin
                hold      = LONG_HOLD;
                held_long = 1'b1;
            end
            if (hold > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Compare each likelihood transfer with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_likelihoods.size() == 0) begin
                $display("%0t: unexpected likelihood, expected none, actual %0d",
                         $time, o_likelihood);
                errors++;
            end else begin
                want_lik = pending_likelihoods.pop_front();
                results_seen++;
                if (o_likelihood !== want_lik) begin
                    $display("%0t: likelihood mismatch, expected %0d, actual %0d",
                             $time, want_lik, o_likelihood);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("noisy_or_nor_node_likelihood verification failed");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        int      counted;
        int      phase;
        int      phase_items;
        int      group_len;
        t_parent p;

        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_index       = nonl_pkg::CFG_NODE_STATE;
        i_cfg_data        = '0;
        i_in_valid        = 1'b0;
        i_parent_weight   = '0;
        i_parent_strength = '0;
        i_parent_active   = 1'b0;
        i_parent_sign     = nonl_pkg::SIGN_NEUTRAL;
        i_last_parent     = 1'b0;
        errors            = 0;
        results_seen      = 0;
        no_idle           = 1'b0;
        node_sel          = nonl_pkg::NODE_ZERO;
        leak_zero         = '0;
        leak_one          = '0;
        leak_two          = '0;
        clear_products();

        // Right after reset every leak is zero, so a lone neutral parent gives zero.
        add_item('0, '0, 1'b0, nonl_pkg::SIGN_NEUTRAL, 1'b1, 1'b1, '0);
        // Sign three is ignored; full leak gives one.
        add_write(nonl_pkg::CFG_BG_ZERO, UNITY);
        add_item(UNITY, UNITY, 1'b1, nonl_pkg::SIGN_UNUSED, 1'b1, 1'b1, UNITY);
        // Leak register above one saturates.
        add_write(nonl_pkg::CFG_BG_ZERO, MAX_CODE);
        add_item('0, MAX_CODE, 1'b1, nonl_pkg::SIGN_INHIBIT, 1'b1, 1'b1, UNITY);
        add_item(UNITY, '0, 1'b0, nonl_pkg::SIGN_INHIBIT, 1'b1, 1'b1, '0);
        // Weight and strength above one saturate.
        add_item(MAX_CODE, MAX_CODE, 1'b1, nonl_pkg::SIGN_INHIBIT, 1'b1, 1'b1, UNITY);
        add_item(UNITY, '0, 1'b1, nonl_pkg::SIGN_ACTIVATE, 1'b1, 1'b1, '0);
        add_item(t_prob'('h8000), t_prob'('h4000), 1'b1, nonl_pkg::SIGN_INHIBIT,
                 1'b0, 1'b0, '0);
        add_item(t_prob'('h3000), '0, 1'b0, nonl_pkg::SIGN_ACTIVATE, 1'b0, 1'b0, '0);
        add_item(t_prob'('h1234), UNITY, 1'b1, nonl_pkg::SIGN_NEUTRAL, 1'b0, 1'b0, '0);
        add_item(t_prob'('hFFFF), t_prob'(1), 1'b1, nonl_pkg::SIGN_INHIBIT,
                 1'b1, 1'b0, '0);
        // Node state one.
        add_write(nonl_pkg::CFG_NODE_STATE, t_prob'(nonl_pkg::NODE_ONE));
        add_write(nonl_pkg::CFG_BG_ONE, t_prob'('h8000));
        add_item('0, '0, 1'b0, nonl_pkg::SIGN_NEUTRAL, 1'b1, 1'b1, t_prob'('h8000));
        add_item(t_prob'('h6000), t_prob'('h2000), 1'b1, nonl_pkg::SIGN_INHIBIT,
                 1'b0, 1'b0, '0);
        add_item(t_prob'('hA000), t_prob'('h9000), 1'b0, nonl_pkg::SIGN_ACTIVATE,
                 1'b1, 1'b0, '0);
        // Node state two.
        add_write(nonl_pkg::CFG_NODE_STATE, t_prob'(nonl_pkg::NODE_TWO));
        add_write(nonl_pkg::CFG_BG_TWO, UNITY);
        add_item(t_prob'('h4000), t_prob'('h8000), 1'b1, nonl_pkg::SIGN_ACTIVATE,
                 1'b0, 1'b0, '0);
        add_item(t_prob'('hC000), t_prob'('h1000), 1'b1, nonl_pkg::SIGN_INHIBIT,
                 1'b0, 1'b0, '0);
        add_item(t_prob'('h2000), '0, 1'b0, nonl_pkg::SIGN_UNUSED, 1'b1, 1'b0, '0);
        add_item('0, '0, 1'b0, nonl_pkg::SIGN_NEUTRAL, 1'b1, 1'b1, UNITY);
        // Invalid node state gives zero and still clears the products.
        add_write(nonl_pkg::CFG_NODE_STATE, t_prob'(nonl_pkg::NODE_INVALID));
        add_item(t_prob'('h5000), t_prob'('h7000), 1'b1, nonl_pkg::SIGN_INHIBIT,
                 1'b1, 1'b1, '0);
        add_write(nonl_pkg::CFG_NODE_STATE, t_prob'(nonl_pkg::NODE_TWO));
        add_item('0, '0, 1'b0, nonl_pkg::SIGN_NEUTRAL, 1'b1, 1'b1, UNITY);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_write) begin
                write_register(directed_rows[k].sel, directed_rows[k].value);
            end else begin
                send_parent(directed_rows[k].par, directed_rows[k].typed,
                            directed_rows[k].typed_lik);
            end
        end

        // Random evaluations, mostly short, a few long; one phase in four
        // runs both channels without idle cycles.
        counted = 0;
        phase   = 0;
        while (counted < RANDOM_ITEMS) begin
            retune_phase(phase);
            no_idle     = (phase % 4 == 2);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS && counted < RANDOM_ITEMS) begin
                group_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                        : $urandom_range(1, 4);
                for (int j = 0; j < group_len; j++) begin
                    p = random_parent(j == group_len - 1);
                    send_parent(p, 1'b0, '0);
                    counted++;
                    phase_items++;
                end
            end
            phase++;
        end
        no_idle = 1'b0;

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_likelihoods.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) begin
            $display("noisy_or_nor_node_likelihood verification clean");
        end else begin
            $display("noisy_or_nor_node_likelihood verification failed");
        end
        $finish;
    end

endmodule
